// ----- rtl/srtf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, status codes and types for the shortest-remaining-time scheduler.
// No dependencies; imported by srtf_cell, the top level, the checker and the testbench.
package srtf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int TIME_W      = 16;
  localparam int WAIT_W      = 32;
  localparam int STAT_W      = 3;
  localparam int QCNT_W      = 5;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd2;
  localparam logic [STAT_W-1:0] ST_IDLE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_RAN      = 3'd4;
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]   job;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] burst;
    logic [WAIT_W-1:0] wait_cnt;
  } slot_t;

  typedef struct packed {
    logic              ins;
    logic              tick;
    logic              pop;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] burst;
  } slot_cmd_t;

endpackage

// ----- rtl/srtf_cell.sv -----
`timescale 1ns / 1ps
// One queue slot of the sorted scheduler chain: holds a job, ages it on a tick,
// and shifts toward its neighbors on insert or pop. Depends on srtf_pkg.
module srtf_cell (
  input  logic               clk,
  input  srtf_pkg::slot_cmd_t cmd,
  input  logic               is_head,
  input  logic               occ,
  input  logic               left_le,
  input  srtf_pkg::slot_t    left_cur,
  input  srtf_pkg::slot_t    right_aged,
  output logic               le,
  output srtf_pkg::slot_t    cur,
  output srtf_pkg::slot_t    aged
);
  import srtf_pkg::*;

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    aged = slot_r;
    if (is_head) begin
      if (slot_r.remaining != '0) begin
        aged.remaining = slot_r.remaining - TIME_W'(1);
      end
    end else if (slot_r.wait_cnt != '1) begin
      aged.wait_cnt = slot_r.wait_cnt + WAIT_W'(1);
    end
  end

  assign le  = occ && (slot_r.remaining <= cmd.burst);
  assign cur = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.ins) begin
      if (!le) begin
        if (left_le) begin
          slot_nxt.job       = cmd.id;
          slot_nxt.remaining = cmd.burst;
          slot_nxt.burst     = cmd.burst;
          slot_nxt.wait_cnt  = '0;
        end else begin
          slot_nxt = left_cur;
        end
      end
    end else if (cmd.tick) begin
      if (cmd.pop) begin
        slot_nxt = right_aged;
      end else if (occ) begin
        slot_nxt = aged;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// ----- rtl/shortest_remaining_time_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Top level of the shortest-remaining-time-first scheduler: a chain of srtf_cell
// slots kept sorted by remaining time, plus the result register. Depends on srtf_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall): op 0 is a job arrival carrying in_job_id and
//   in_burst_length; op 1 is one time tick. Every transfer yields exactly one result.
//   Result channel (out_valid/out_stall): status, running job, wait and turnaround of
//   a finished job, and the queue occupancy after the item.
//   The result is registered: the result of an item accepted at one edge is
//   presented from the next edge on. One item is taken per cycle while in_stall is
//   low; every slot inserts, ages or shifts in parallel, so queue fill does not slow it.
//   The queue holds QUEUE_DEPTH jobs. Arrivals to a full queue are dropped and
//   zero-length bursts rejected, each with its own status.
//   Reset (rst_n low, synchronous) empties the queue and the result register;
//   slot contents are not cleared and are never read until written.
//   While out_stall holds a pending result, in_stall is raised and the result holds.
module shortest_remaining_time_scheduler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic [srtf_pkg::ID_W-1:0]    in_job_id,
  input  logic [srtf_pkg::TIME_W-1:0]  in_burst_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [srtf_pkg::STAT_W-1:0]  out_status,
  output logic [srtf_pkg::ID_W-1:0]    out_running_job,
  output logic [srtf_pkg::WAIT_W-1:0]  out_done_wait,
  output logic [srtf_pkg::WAIT_W-1:0]  out_done_turnaround,
  output logic [srtf_pkg::QCNT_W-1:0]  out_jobs_queued
);
  import srtf_pkg::*;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [STAT_W-1:0]  status_r;
  logic [STAT_W-1:0]  status_nxt;
  logic [ID_W-1:0]    run_job_r;
  logic [ID_W-1:0]    run_job_nxt;
  logic [WAIT_W-1:0]  done_wait_r;
  logic [WAIT_W-1:0]  done_wait_nxt;
  logic [WAIT_W-1:0]  done_tat_r;
  logic [WAIT_W-1:0]  done_tat_nxt;

  logic               take;
  logic               full;
  logic               empty;
  logic [WAIT_W:0]    tat_sum;
  slot_cmd_t          cmd;

  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH-1:0] le;
  slot_t                  cur  [QUEUE_DEPTH];
  slot_t                  aged [QUEUE_DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    cmd.ins   = take && (in_op == OP_ARRIVE) && (in_burst_length != '0) && !full;
    cmd.tick  = take && (in_op == OP_TICK) && !empty;
    cmd.pop   = cmd.tick && (cur[0].remaining <= TIME_W'(1));
    cmd.id    = in_job_id;
    cmd.burst = in_burst_length;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic  left_le_i;
    slot_t left_cur_i;
    slot_t right_aged_i;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_le_i  = 1'b1;
      assign left_cur_i = '0;
    end else begin : g_body
      assign left_le_i  = le[i-1];
      assign left_cur_i = cur[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_aged_i = '0;
    end else begin : g_inner
      assign right_aged_i = aged[i+1];
    end

    srtf_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .is_head    ((i == 0) ? 1'b1 : 1'b0),
      .occ        (occ[i]),
      .left_le    (left_le_i),
      .left_cur   (left_cur_i),
      .right_aged (right_aged_i),
      .le         (le[i]),
      .cur        (cur[i]),
      .aged       (aged[i])
    );
  end

  assign tat_sum = {1'b0, cur[0].wait_cnt} + (WAIT_W + 1)'(cur[0].burst);

  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    run_job_nxt   = run_job_r;
    done_wait_nxt = done_wait_r;
    done_tat_nxt  = done_tat_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (take) begin
      out_valid_nxt = 1'b1;
      run_job_nxt   = '0;
      done_wait_nxt = '0;
      done_tat_nxt  = '0;
      if (in_op == OP_ARRIVE) begin
        if (in_burst_length == '0) begin
          status_nxt = ST_ZERO;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_ACCEPTED;
          count_nxt  = count_r + CNT_W'(1);
        end
      end else if (empty) begin
        status_nxt = ST_IDLE;
      end else if (cmd.pop) begin
        status_nxt    = ST_DONE;
        run_job_nxt   = cur[0].job;
        done_wait_nxt = cur[0].wait_cnt;
        done_tat_nxt  = tat_sum[WAIT_W] ? '1 : tat_sum[WAIT_W-1:0];
        count_nxt     = count_r - CNT_W'(1);
      end else begin
        status_nxt  = ST_RAN;
        run_job_nxt = cur[0].job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    run_job_r   <= run_job_nxt;
    done_wait_r <= done_wait_nxt;
    done_tat_r  <= done_tat_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_running_job     = run_job_r;
  assign out_done_wait       = done_wait_r;
  assign out_done_turnaround = done_tat_r;
  assign out_jobs_queued     = QCNT_W'(count_r);

endmodule

// ----- bench/srtf_sched_checker.sv -----
`timescale 1ns / 1ps
// Checker for the shortest-remaining-time scheduler: mirrors the sorted job queue,
// predicts each result and compares it with the result channel. Depends on srtf_pkg.
module srtf_sched_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_op,
  input  logic [srtf_pkg::ID_W-1:0]     in_job_id,
  input  logic [srtf_pkg::TIME_W-1:0]   in_burst_length,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [srtf_pkg::STAT_W-1:0]   out_status,
  input  logic [srtf_pkg::ID_W-1:0]     out_running_job,
  input  logic [srtf_pkg::WAIT_W-1:0]   out_done_wait,
  input  logic [srtf_pkg::WAIT_W-1:0]   out_done_turnaround,
  input  logic [srtf_pkg::QCNT_W-1:0]   out_jobs_queued,
  output int                            mismatches,
  output int                            pending
);
  import srtf_pkg::*;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   job;
    logic [WAIT_W-1:0] wait_ticks;
    logic [WAIT_W-1:0] turnaround;
    logic [QCNT_W-1:0] queued;
  } sched_result_t;

  slot_t         jobs [QUEUE_DEPTH];
  int unsigned   job_count;
  sched_result_t expected_results [$];

  function automatic sched_result_t schedule_item(logic op, logic [ID_W-1:0] id,
                                                  logic [TIME_W-1:0] burst);
    sched_result_t res;
    int            pos;
    logic [WAIT_W:0] sum;
    res.status     = ST_ACCEPTED;
    res.job        = '0;
    res.wait_ticks = '0;
    res.turnaround = '0;
    if (op == OP_ARRIVE) begin
      if (burst == '0) begin
        res.status = ST_ZERO;
      end else if (job_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < int'(job_count) && jobs[pos].remaining <= burst) pos++;
        for (int i = int'(job_count); i > pos; i--) jobs[i] = jobs[i-1];
        jobs[pos].job       = id;
        jobs[pos].remaining = burst;
        jobs[pos].burst     = burst;
        jobs[pos].wait_cnt  = '0;
        job_count++;
      end
    end else if (job_count == 0) begin
      res.status = ST_IDLE;
    end else begin
      for (int i = 1; i < int'(job_count); i++)
        if (jobs[i].wait_cnt != '1) jobs[i].wait_cnt++;
      if (jobs[0].remaining != '0) jobs[0].remaining--;
      res.job = jobs[0].job;
      if (jobs[0].remaining == '0) begin
        res.status     = ST_DONE;
        res.wait_ticks = jobs[0].wait_cnt;
        sum            = {1'b0, jobs[0].wait_cnt} + (WAIT_W + 1)'(jobs[0].burst);
        res.turnaround = sum[WAIT_W] ? '1 : sum[WAIT_W-1:0];
        for (int i = 0; i + 1 < int'(job_count); i++) jobs[i] = jobs[i+1];
        job_count--;
      end else begin
        res.status = ST_RAN;
      end
    end
    res.queued = job_count[QCNT_W-1:0];
    return res;
  endfunction

  task automatic compare_field(string field, logic [WAIT_W-1:0] want,
                               logic [WAIT_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      job_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: status expected none actual %0h", $time, out_status);
        end else begin
          want = expected_results.pop_front();
          compare_field("status", WAIT_W'(want.status), WAIT_W'(out_status));
          compare_field("running_job", WAIT_W'(want.job), WAIT_W'(out_running_job));
          compare_field("done_wait", want.wait_ticks, out_done_wait);
          compare_field("done_turnaround", want.turnaround, out_done_turnaround);
          compare_field("jobs_queued", WAIT_W'(want.queued), WAIT_W'(out_jobs_queued));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(schedule_item(in_op, in_job_id, in_burst_length));
    end
    pending <= expected_results.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for shortest_remaining_time_scheduler_unit: clock, reset, job and tick
// stimulus, result-side stalls and the verdict. Depends on srtf_pkg and srtf_sched_checker.
module tb;
  import srtf_pkg::*;

  localparam int RANDOM_ITEMS = 1430;
  localparam int QUIET_LIMIT  = 2000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_op = OP_ARRIVE;
  logic [ID_W-1:0]     in_job_id = '0;
  logic [TIME_W-1:0]   in_burst_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [ID_W-1:0]     out_running_job;
  logic [WAIT_W-1:0]   out_done_wait;
  logic [WAIT_W-1:0]   out_done_turnaround;
  logic [QCNT_W-1:0]   out_jobs_queued;

  int checker_errors;
  int pending;
  int sent_items = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  always #5 clk = ~clk;

  shortest_remaining_time_scheduler_unit u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_job_id, .in_burst_length,
    .out_valid, .out_stall, .out_status, .out_running_job, .out_done_wait,
    .out_done_turnaround, .out_jobs_queued
  );

  srtf_sched_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_job_id, .in_burst_length,
    .out_valid, .out_stall, .out_status, .out_running_job, .out_done_wait,
    .out_done_turnaround, .out_jobs_queued,
    .mismatches(checker_errors), .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 85) return TIME_W'($urandom_range(1, 8));
    return TIME_W'($urandom_range(9, 64));
  endfunction

  task automatic send_item(input logic op, input logic [ID_W-1:0] id,
                           input logic [TIME_W-1:0] burst);
    int gap;
    in_valid        <= 1'b1;
    in_op           <= op;
    in_job_id       <= id;
    in_burst_length <= burst;
    do @(posedge clk); while (in_stall);
    sent_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int  r;
    int  len;
    bit  lvl;
    bit  hold_done;
    hold_done = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (!hold_done && sent_items >= 400) begin
        lvl       = 1'b1;
        len       = 80;
        hold_done = 1'b1;
      end else if (r < 50) begin
        lvl = 1'b0;
        len = $urandom_range(1, 8);
      end else if (r < 85) begin
        lvl = 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 95) begin
        lvl = 1'b0;
        len = $urandom_range(20, 60);
      end else begin
        lvl = 1'b1;
        len = $urandom_range(10, 30);
      end
      out_stall <= lvl;
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[shortest_remaining_time_scheduler_unit] ERROR");
    $finish;
  end

  initial begin
    int n;
    int k;
    int len;
    bit fill;
    bit is_tick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, zero burst, extremes, ties, duplicates, preemption
    send_item(OP_TICK, 8'h00, 16'h0000);
    send_item(OP_ARRIVE, 8'h00, 16'h0000);
    send_item(OP_ARRIVE, 8'hFF, 16'hFFFF);
    send_item(OP_ARRIVE, 8'h00, 16'h0001);
    send_item(OP_TICK, 8'hFF, 16'hFFFF);
    send_item(OP_ARRIVE, 8'hA5, 16'd3);
    send_item(OP_ARRIVE, 8'h5A, 16'd3);
    send_item(OP_ARRIVE, 8'hA5, 16'd2);
    repeat (8) send_item(OP_TICK, 8'h00, 16'h0000);
    send_item(OP_ARRIVE, 8'h11, 16'd5);
    send_item(OP_TICK, 8'h00, 16'h0000);
    send_item(OP_TICK, 8'h00, 16'h0000);
    send_item(OP_ARRIVE, 8'h22, 16'd1);
    repeat (4) send_item(OP_TICK, 8'h00, 16'h0000);
    drain_results();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      fill   = ($urandom_range(0, 1) == 1);
      steady = ($urandom_range(0, 3) == 0);
      len    = $urandom_range(5, 40);
      for (k = 0; k < len && n < RANDOM_ITEMS; k++) begin
        if (n == RANDOM_ITEMS / 2) drain_results();
        is_tick = $urandom_range(0, 99) < (fill ? 20 : 85);
        if (is_tick)
          send_item(OP_TICK, ID_W'($urandom_range(0, 255)),
                    TIME_W'($urandom_range(0, 65535)));
        else
          send_item(OP_ARRIVE,
                    ID_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 255)),
                    pick_burst());
        n++;
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (checker_errors == 0)
      $display("[shortest_remaining_time_scheduler_unit] OK");
    else
      $display("[shortest_remaining_time_scheduler_unit] ERROR");
    $finish;
  end

endmodule
